FILE: hdl/fle_pkg.sv
// Package: constants, codes and the sine table generator for the faded LFO evaluator.
`default_nettype none

package fle_pkg;

  localparam int unsigned FALLBACK_CYCLE_TICKS_DEF = 240;
  localparam int unsigned SINE_TABLE_ENTRIES_DEF   = 256;
  localparam int unsigned PHASE_FRACTION_BITS_DEF  = 16;

  localparam int unsigned Q15_ONE     = 32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_START  = 4'd0,
    REG_REGION_END    = 4'd1,
    REG_CYCLE_TICKS   = 4'd2,
    REG_PHASE_OFFSET  = 4'd3,
    REG_WAVE_MODE     = 4'd4,
    REG_AMPLITUDE     = 4'd5,
    REG_ATTACK_TICKS  = 4'd6,
    REG_RELEASE_TICKS = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_TRIANGLE = 3'd1,
    SHAPE_RAMP_UP  = 3'd2,
    SHAPE_RAMP_DN  = 3'd3,
    SHAPE_SQUARE   = 3'd4
  } shape_e;

  // Quarter-wave entry from a Q30 angle, Taylor series to the 15th power.
  function automatic logic [15:0] sine_from_x(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 64'sd32768 + 64'sd536870912) >>> 30;
    if (v > 64'sd32768) begin
      v = 64'sd32768;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fle_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module fle_div_pipe #(
  parameter int unsigned DW = 24,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [QW-1:0] num_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o,
  output logic [SW-1:0]      side_o
);

  logic          vld_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] acc_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [QW-1:0] a_in;
    logic [SW-1:0] sd_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = rem_i;
      assign a_in  = num_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = vld_q[s-1];
      assign r_in  = rem_q[s-1];
      assign a_in  = acc_q[s-1];
      assign sd_in = side_q[s-1];
    end

    assign t    = {r_in, a_in[QW-1]};
    assign diff = t - {1'b0, den_i};
    assign ge   = (t >= {1'b0, den_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        acc_q[s]  <= {a_in[QW-2:0], ge};
        side_q[s] <= sd_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = acc_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

FILE: hdl/faded_lfo_waveform_evaluator.sv
// Top level: faded LFO waveform evaluator, fully pipelined.
//
// Input channel: tick_position_i with in_valid_i / in_stall_o. Output channel:
// in_region_o and level_o with out_valid_o / out_stall_i. A transfer happens
// on a rising edge with valid high and stall low.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i; write only
// while no transfer is in flight.
// Throughput: one position per cycle while out_stall_i is not holding a
// waiting result. The bit-per-stage dividers set the pipeline depth: 15 stages
// for the fades, 32 for the cycle remainder and one per phase bit.
// The whole pipeline advances together; when out_stall_i holds a waiting
// result, every stage holds and in_stall_o is raised, nothing is dropped.
// Reset clears all stage valid bits and loads register defaults (amplitude
// one, all else zero).
`default_nettype none

module faded_lfo_waveform_evaluator #(
  parameter int unsigned FALLBACK_CYCLE_TICKS = fle_pkg::FALLBACK_CYCLE_TICKS_DEF,
  parameter int unsigned SINE_TABLE_ENTRIES   = fle_pkg::SINE_TABLE_ENTRIES_DEF,
  parameter int unsigned PHASE_FRACTION_BITS  = fle_pkg::PHASE_FRACTION_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fle_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [31:0]                     tick_position_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 in_region_o,
  output logic [15:0]                          level_o
);

  import fle_pkg::*;

  localparam int unsigned P  = PHASE_FRACTION_BITS;
  localparam int unsigned N  = SINE_TABLE_ENTRIES;
  localparam int unsigned IW = $clog2(N + 1);
  localparam int unsigned UP = (P >= 16) ? P - 16 : 0;
  localparam int unsigned DN = (P >= 16) ? 0 : 16 - P;
  localparam logic [P-1:0] HALF = P'(1) << (P - 1);

  // configuration registers
  logic [31:0] start_q, end_q;
  logic [23:0] cycle_q, attack_q, release_q;
  logic [15:0] phofs_q, amp_q;
  logic [3:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      end_q     <= '0;
      cycle_q   <= '0;
      phofs_q   <= '0;
      mode_q    <= '0;
      amp_q     <= 16'(Q15_ONE);
      attack_q  <= '0;
      release_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_REGION_START:  start_q   <= cfg_data_i;
        REG_REGION_END:    end_q     <= cfg_data_i;
        REG_CYCLE_TICKS:   cycle_q   <= cfg_data_i[23:0];
        REG_PHASE_OFFSET:  phofs_q   <= cfg_data_i[15:0];
        REG_WAVE_MODE:     mode_q    <= cfg_data_i[3:0];
        REG_AMPLITUDE:     amp_q     <= (cfg_data_i[15:0] > 16'(Q15_ONE)) ? 16'(Q15_ONE)
                                                                        : cfg_data_i[15:0];
        REG_ATTACK_TICKS:  attack_q  <= cfg_data_i[23:0];
        REG_RELEASE_TICKS: release_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  logic [23:0]  cyc_eff;
  logic [P-1:0] ofs_p;
  logic [P+15:0] ofs_wide;

  assign cyc_eff  = (cycle_q == '0) ? 24'(FALLBACK_CYCLE_TICKS) : cycle_q;
  assign ofs_wide = ((P + 16)'(phofs_q) << UP) >> DN;
  assign ofs_p    = ofs_wide[P-1:0];

  // pipeline advance
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: capture position
  logic        v1_q;
  logic [31:0] pos1_q;

  // stage 2: region test, elapsed, release start
  logic        v2_q, inr2_q;
  logic [31:0] el2_q;
  logic [32:0] rs2_q;

  // stage 3: release distance
  logic        v3_q, inr3_q;
  logic [31:0] el3_q;
  logic [33:0] rd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos1_q <= tick_position_i;
      inr2_q <= (pos1_q >= start_q) && (pos1_q < end_q);
      el2_q  <= pos1_q - start_q;
      rs2_q  <= {1'b0, pos1_q} + {9'd0, release_q};
      inr3_q <= inr2_q;
      el3_q  <= el2_q;
      rd3_q  <= {1'b0, rs2_q} - {2'b0, end_q};
    end
  end

  // fade setup
  logic        a_full, r_full, r_zero, r_neg, r_ge;
  logic [23:0] a_e;

  assign a_full = (attack_q == '0) || (el3_q >= {8'd0, attack_q});
  assign a_e    = (el3_q < {8'd0, attack_q}) ? el3_q[23:0] : attack_q;
  assign r_neg  = rd3_q[33];
  assign r_ge   = !r_neg && (rd3_q[32:0] >= {9'd0, release_q});
  assign r_full = (release_q == '0) || r_neg;
  assign r_zero = !r_full && r_ge;

  // fade dividers
  localparam int unsigned FSW = 34;
  logic           fa_v;
  logic [14:0]    fa_q, fr_q;
  logic [FSW-1:0] fa_side;
  logic [1:0]     fr_side;

  fle_div_pipe #(.DW(24), .QW(15), .SW(FSW)) u_div_attack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .den_i   (attack_q),
    .rem_i   (a_e),
    .num_i   ('0),
    .side_i  ({inr3_q, a_full, el3_q}),
    .valid_o (fa_v),
    .quo_o   (fa_q),
    .rem_o   (),
    .side_o  (fa_side)
  );

  fle_div_pipe #(.DW(24), .QW(15), .SW(2)) u_div_release (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .den_i   (release_q),
    .rem_i   (rd3_q[23:0]),
    .num_i   ('0),
    .side_i  ({r_full, r_zero}),
    .valid_o (),
    .quo_o   (fr_q),
    .rem_o   (),
    .side_o  (fr_side)
  );

  logic [15:0] fade_a, fade_r, fade;
  logic        inr_f;
  logic [31:0] el_f;

  assign inr_f  = fa_side[33];
  assign el_f   = fa_side[31:0];
  assign fade_a = fa_side[32] ? 16'(Q15_ONE) : {1'b0, fa_q};
  assign fade_r = fr_side[1] ? 16'(Q15_ONE) :
                  fr_side[0] ? 16'd0 : 16'(Q15_ONE) - {1'b0, fr_q};
  assign fade   = (fade_r < fade_a) ? fade_r : fade_a;

  // elapsed mod cycle
  logic        md_v;
  logic [23:0] md_rem;
  logic [16:0] md_side;

  fle_div_pipe #(.DW(24), .QW(32), .SW(17)) u_div_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fa_v),
    .den_i   (cyc_eff),
    .rem_i   ('0),
    .num_i   (el_f),
    .side_i  ({inr_f, fade}),
    .valid_o (md_v),
    .quo_o   (),
    .rem_o   (md_rem),
    .side_o  (md_side)
  );

  // phase fraction
  logic         ph_v;
  logic [P-1:0] ph_raw;
  logic [16:0]  ph_side;

  fle_div_pipe #(.DW(24), .QW(P), .SW(17)) u_div_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (md_v),
    .den_i   (cyc_eff),
    .rem_i   (md_rem),
    .num_i   ('0),
    .side_i  (md_side),
    .valid_o (ph_v),
    .quo_o   (ph_raw),
    .rem_o   (),
    .side_o  (ph_side)
  );

  // sine quarter table
  logic [15:0] sine_tab [N+1];
  for (genvar k = 0; k <= N; k++) begin : g_sine
    localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(k)) / 64'(N);
    localparam logic [15:0] SK = sine_from_x(XK);
    assign sine_tab[k] = SK;
  end

  // W1: phase with offset
  logic         w1_v_q, w1_inr_q;
  logic [15:0]  w1_fade_q;
  logic [P-1:0] w1_ph_q;

  // W2: table index and other shapes
  logic              w2_v_q, w2_inr_q, w2_neg_q;
  logic [15:0]       w2_fade_q;
  logic [IW-1:0]     w2_idx_q;
  logic signed [17:0] w2_b_q;

  // W3: bipolar wave
  logic              w3_v_q, w3_inr_q;
  logic [15:0]       w3_fade_q;
  logic signed [17:0] w3_b_q;

  // W4: amplitude scaled
  logic        w4_v_q, w4_inr_q;
  logic [15:0] w4_fade_q, w4_m_q;

  logic in_region_q;
  logic [15:0] level_q;

  // W2 logic
  logic [1:0]        quad;
  logic [P-3:0]      qrest;
  logic [P-3+IW:0]   iprod;
  logic [IW-1:0]     idx0, idx;
  logic [P-1:0]      tri_d;
  logic [P+16:0]     tri_sh;
  logic [P+15:0]     ramp_sh;
  logic signed [17:0] b_tri, b_rup, b_rdn, b_sq, b_other;

  assign quad    = w1_ph_q[P-1:P-2];
  assign qrest   = w1_ph_q[P-3:0];
  assign iprod   = (P - 2 + IW)'(qrest) * (P - 2 + IW)'(N);
  assign idx0    = iprod[P-3+IW:P-2];
  assign idx     = quad[0] ? IW'(N) - idx0 : idx0;
  assign tri_d   = (w1_ph_q >= HALF) ? w1_ph_q - HALF : HALF - w1_ph_q;
  assign tri_sh  = {tri_d, 17'd0};
  assign ramp_sh = {w1_ph_q, 16'd0};
  assign b_tri   = 18'sd32768 - signed'({1'b0, tri_sh[P+16:P]});
  assign b_rup   = signed'({2'b0, ramp_sh[P+15:P]}) - 18'sd32768;
  assign b_rdn   = 18'sd32768 - signed'({2'b0, ramp_sh[P+15:P]});
  assign b_sq    = (w1_ph_q < HALF) ? 18'sd32768 : -18'sd32768;

  always_comb begin
    case (shape_e'(mode_q[3:1]))
      SHAPE_TRIANGLE: b_other = b_tri;
      SHAPE_RAMP_UP:  b_other = b_rup;
      SHAPE_RAMP_DN:  b_other = b_rdn;
      SHAPE_SQUARE:   b_other = b_sq;
      default:        b_other = '0;
    endcase
  end

  // W3 logic
  logic signed [17:0] b_sine;
  assign b_sine = w2_neg_q ? -signed'({2'b0, sine_tab[w2_idx_q]})
                           : signed'({2'b0, sine_tab[w2_idx_q]});

  // W4 logic
  logic [15:0] u;
  logic [31:0] ua;
  assign u  = mode_q[0] ? ((w3_b_q > 0) ? w3_b_q[15:0] : 16'd0)
                        : 16'((w3_b_q + 18'sd32768) >>> 1);
  assign ua = 32'(u) * 32'(amp_q);

  // W5 logic
  logic [31:0] mf;
  assign mf = 32'(w4_m_q) * 32'(w4_fade_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_v_q      <= 1'b0;
      w2_v_q      <= 1'b0;
      w3_v_q      <= 1'b0;
      w4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      w1_v_q      <= ph_v;
      w2_v_q      <= w1_v_q;
      w3_v_q      <= w2_v_q;
      w4_v_q      <= w3_v_q;
      out_valid_q <= w4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_inr_q  <= ph_side[16];
      w1_fade_q <= ph_side[15:0];
      w1_ph_q   <= ph_raw + ofs_p;

      w2_inr_q  <= w1_inr_q;
      w2_fade_q <= w1_fade_q;
      w2_idx_q  <= idx;
      w2_neg_q  <= quad[1];
      w2_b_q    <= b_other;

      w3_inr_q  <= w2_inr_q;
      w3_fade_q <= w2_fade_q;
      w3_b_q    <= (shape_e'(mode_q[3:1]) == SHAPE_SINE) ? b_sine : w2_b_q;

      w4_inr_q  <= w3_inr_q;
      w4_fade_q <= w3_fade_q;
      w4_m_q    <= ua[30:15];

      in_region_q <= w4_inr_q;
      level_q     <= w4_inr_q ? mf[30:15] : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_region_o = in_region_q;
  assign level_o     = level_q;

endmodule

`default_nettype wire

FILE: tb/sv/faded_lfo_waveform_evaluator_test.sv
// Testbench: faded LFO evaluator checked against an in-bench level predictor.
`timescale 1ns / 100ps
`default_nettype none

module faded_lfo_waveform_evaluator_test;
  import fle_pkg::*;

  localparam int unsigned FALLBACK = 240;
  localparam int unsigned SINE_N = 256;
  localparam int unsigned PBITS = 16;
  localparam int unsigned LATENCY = 23 + 32 + PBITS;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 1950;

  typedef struct packed {
    logic        in_region;
    logic [15:0] level;
  } lfo_result_t;

  typedef struct {
    logic [31:0] pos;
    logic        known;
    lfo_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] tick_position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic in_region_o;
  logic [15:0] level_o;

  faded_lfo_waveform_evaluator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] r_start, r_end;
  logic [23:0] r_cycle, r_attack, r_release;
  logic [15:0] r_offset, r_amp;
  logic [3:0] r_mode;
  logic [15:0] sine_tab [0:SINE_N];

  lfo_result_t pending_levels[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic logic [15:0] quarter_sine(int unsigned k);
    logic [63:0] x, x2, term;
    longint sum, v;
    x = (HALF_PI_Q30 * k) / SINE_N;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum * 32768 + (64'sd1 << 29)) >>> 30;
    if (v > 32768) v = 32768;
    return v[15:0];
  endfunction

  function automatic lfo_result_t predict_level(logic [31:0] pos);
    lfo_result_t r;
    longint unsigned elapsed, cyc, ph, u, amp, fade, rfade, e, rs, d, q, idx;
    longint b;
    r = '0;
    if (pos < r_start || pos >= r_end) return r;
    elapsed = pos - r_start;
    cyc = (r_cycle != 0) ? r_cycle : FALLBACK;
    ph = ((elapsed % cyc) << PBITS) / cyc;
    ph = (ph + r_offset) & ((64'd1 << PBITS) - 1);
    case (r_mode >> 1)
      SHAPE_SINE: begin
        q = (ph >> (PBITS - 2)) & 3;
        idx = ((ph & ((64'd1 << (PBITS - 2)) - 1)) * SINE_N) >> (PBITS - 2);
        if (q & 1) idx = SINE_N - idx;
        b = (q & 2) ? -longint'(sine_tab[idx]) : longint'(sine_tab[idx]);
      end
      SHAPE_TRIANGLE: begin
        d = (ph >= 32768) ? ph - 32768 : 32768 - ph;
        b = 32768 - longint'((d << 17) >> PBITS);
      end
      SHAPE_RAMP_UP: b = longint'((ph << 16) >> PBITS) - 32768;
      SHAPE_RAMP_DN: b = 32768 - longint'((ph << 16) >> PBITS);
      SHAPE_SQUARE: b = (ph < 32768) ? 32768 : -32768;
      default: b = 0;
    endcase
    if (r_mode[0]) u = (b > 0) ? b : 0;
    else u = longint'(b + 32768) >> 1;
    amp = (r_amp > 32768) ? 32768 : r_amp;
    fade = 32768;
    if (r_attack != 0) begin
      e = (elapsed < r_attack) ? elapsed : r_attack;
      fade = (e << 15) / r_attack;
    end
    rfade = 32768;
    if (r_release != 0) begin
      rs = longint'(pos) + r_release;
      if (rs >= r_end) begin
        e = rs - r_end;
        if (e > r_release) e = r_release;
        rfade = 32768 - (e << 15) / r_release;
      end
    end
    if (rfade < fade) fade = rfade;
    r.in_region = 1'b1;
    r.level = 16'((((u * amp) >> 15) * fade) >> 15);
    return r;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    case (idx)
      REG_REGION_START: r_start = value;
      REG_REGION_END: r_end = value;
      REG_CYCLE_TICKS: r_cycle = value[23:0];
      REG_PHASE_OFFSET: r_offset = value[15:0];
      REG_WAVE_MODE: r_mode = value[3:0];
      REG_AMPLITUDE: r_amp = value[15:0];
      REG_ATTACK_TICKS: r_attack = value[23:0];
      REG_RELEASE_TICKS: r_release = value[23:0];
      default: ;
    endcase
  endtask

  task automatic drain_pipeline();
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic send_position(logic [31:0] pos);
    cfg_we_i <= 1'b0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    pending_levels.insert(pending_levels.size(), predict_level(pos));
    @(negedge clk_i);
  endtask

  task automatic random_config();
    logic [31:0] s;
    s = (($urandom_range(3) == 0) ? $urandom : $urandom_range(5000));
    write_reg(REG_REGION_START, s);
    write_reg(REG_REGION_END, ($urandom_range(7) == 0) ? $urandom : s + $urandom_range(4000));
    write_reg(REG_CYCLE_TICKS, ($urandom_range(4) == 0) ? 0 :
              ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 1000));
    write_reg(REG_PHASE_OFFSET, $urandom);
    write_reg(REG_WAVE_MODE, $urandom_range(15));
    write_reg(REG_AMPLITUDE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32768));
    write_reg(REG_ATTACK_TICKS, ($urandom_range(2) == 0) ? 0 :
              ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 1500));
    write_reg(REG_RELEASE_TICKS, ($urandom_range(2) == 0) ? 0 :
              ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 1500));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected result in_region=%0d level=%0d", in_region_o, level_o);
        errors++;
      end else begin
        lfo_result_t want;
        want = pending_levels.pop_front();
        if (in_region_o !== want.in_region) begin
          $error("in_region expected %0d actual %0d", want.in_region, in_region_o);
          errors++;
        end
        if (level_o !== want.level) begin
          $error("level expected %0d actual %0d", want.level, level_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  stim_row_t directed[$];

  initial begin
    int unsigned phase_sel;
    r_start = 0; r_end = 0; r_cycle = 0; r_offset = 0;
    r_mode = 0; r_amp = 32768; r_attack = 0; r_release = 0;
    for (int k = 0; k <= SINE_N; k++) sine_tab[k] = quarter_sine(k);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty region after reset: everything out of region
    directed.insert(directed.size(), '{32'd0, 1'b1, '{1'b0, 16'd0}});
    directed.insert(directed.size(), '{32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd0}});
    foreach (directed[i]) begin
      send_position(directed[i].pos);
      if (directed[i].known && predict_level(directed[i].pos) !== directed[i].res) begin
        $error("directed row %0d table disagrees with predictor", i);
        errors++;
      end
    end
    in_valid_i <= 1'b0;
    drain_pipeline();

    write_reg(REG_REGION_START, 32'd100);
    write_reg(REG_REGION_END, 32'hFFFF_FFFF);
    write_reg(REG_WAVE_MODE, 4'd8);
    directed.delete();
    directed.insert(directed.size(), '{32'd99, 1'b1, '{1'b0, 16'd0}});
    directed.insert(directed.size(), '{32'd100, 1'b1, '{1'b1, 16'd32768}});
    directed.insert(directed.size(), '{32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd0}});
    directed.insert(directed.size(), '{32'hFFFF_FFFE, 1'b0, '0});
    for (int m = 0; m < 16; m++) begin
      directed.insert(directed.size(), '{32'd100 + 15 * m, 1'b0, '0});
    end
    foreach (directed[i]) begin
      if (i == 4) begin
        in_valid_i <= 1'b0;
        drain_pipeline();
      end
      if (i >= 4) write_reg(REG_WAVE_MODE, i - 4);
      if (i == 4) begin
        write_reg(REG_AMPLITUDE, 16'hFFFF);
        write_reg(REG_PHASE_OFFSET, 16'hFFFF);
        write_reg(REG_CYCLE_TICKS, 24'hFFFFFF);
        write_reg(REG_ATTACK_TICKS, 24'hFFFFFF);
        write_reg(REG_RELEASE_TICKS, 24'd1);
      end
      send_position(directed[i].pos);
      if (directed[i].known && predict_level(directed[i].pos) !== directed[i].res) begin
        $error("directed row %0d table disagrees with predictor", i);
        errors++;
      end
      if (i >= 3) begin
        in_valid_i <= 1'b0;
        drain_pipeline();
      end
    end
    write_reg(REG_AMPLITUDE, 16'd0);
    write_reg(REG_ATTACK_TICKS, 24'd0);
    write_reg(REG_RELEASE_TICKS, 24'hFFFFFF);
    send_position(32'd500);
    in_valid_i <= 1'b0;
    drain_pipeline();

    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      if (item % 65 == 0) begin
        in_valid_i <= 1'b0;
        drain_pipeline();
        phase_sel = (item / 65) % 4;
        idle_pct = (phase_sel == 1 || phase_sel == 3) ? ((phase_sel == 3) ? 18 : 75) : 0;
        stall_pct = (phase_sel == 2 || phase_sel == 3) ? ((phase_sel == 3) ? 18 : 75) : 0;
        random_config();
      end
      case ($urandom_range(9))
        0: send_position($urandom);
        1: send_position(r_start - $urandom_range(1, 3));
        2: send_position(r_end - $urandom_range(0, 2));
        default: send_position(r_start + $urandom_range(4000));
      endcase
    end
    in_valid_i <= 1'b0;
    drain_pipeline();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/fle_pkg.sv
hdl/fle_div_pipe.sv
hdl/faded_lfo_waveform_evaluator.sv
tb/sv/faded_lfo_waveform_evaluator_test.sv
